/* rtl/core/sesp_pkg.sv */
// Package for the eight-sector sine unit: widths, fixed-point constants,
// the rotation table and the Q31 rounding helper. No dependencies.
`default_nettype none

package sesp_pkg;

  // Sector count (power of two: 4, 8 or 16)
  localparam int SESP_SECTORS = 8;

  // Pipeline layout
  localparam int SESP_STAGES = 14;
  localparam int POLY_FIRST  = 4;
  localparam int POLY_STAGES = 8;

  // Datapath widths
  localparam int DW      = 33;        // Q31 values incl. +1.0
  localparam int PW      = 2 * DW;    // full Q62 product
  localparam int STEP_W  = 50;        // signed reduction step, Q48

  typedef logic signed [DW-1:0] q31_t;
  typedef logic signed [PW-1:0] prod_t;

  localparam logic [63:0]          PI_Q60         = 64'h3243_F6A8_885A_308D;
  localparam logic signed [31:0]   INV_TWO_PI_Q33 = 32'sh517C_C1B7;

  // Polynomial coefficients, Q31
  localparam q31_t P0S = -33'sd357913941;
  localparam q31_t P1S =  33'sd17895697;
  localparam q31_t P2S = -33'sd426088;
  localparam q31_t P0C =  33'sd89478485;
  localparam q31_t P1C = -33'sd2982616;
  localparam q31_t P2C =  33'sd53261;

  localparam q31_t ONE_Q31 = 33'sd2147483648;

  // cos(k*pi/8), Q31
  localparam q31_t C0 = 33'sd2147483648;
  localparam q31_t C1 = 33'sd1984016188;
  localparam q31_t C2 = 33'sd1518500250;
  localparam q31_t C3 = 33'sd821806413;

  localparam prod_t RND31 = prod_t'(64'h0000_0000_4000_0000);

  // Q62 product back to Q31, round half up
  function automatic q31_t rnd31(input prod_t p);
    prod_t s;
    s = p + RND31;
    return q31_t'(s >>> 31);
  endfunction

  // Sixteen-point cosine grid
  function automatic q31_t cos_grid(input logic [3:0] idx);
    q31_t v;
    unique case (idx)
      4'd0:  v = C0;
      4'd1:  v = C1;
      4'd2:  v = C2;
      4'd3:  v = C3;
      4'd4:  v = '0;
      4'd5:  v = -C3;
      4'd6:  v = -C2;
      4'd7:  v = -C1;
      4'd8:  v = -C0;
      4'd9:  v = -C1;
      4'd10: v = -C2;
      4'd11: v = -C3;
      4'd12: v = '0;
      4'd13: v = C3;
      4'd14: v = C2;
      4'd15: v = C1;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

/* rtl/core/sesp_if.sv */
// Stream interfaces for the sine unit: angle in, sine out.
// Valid/ready handshake; no dependencies.
`default_nettype none

interface sesp_angle_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] angle;

  modport source (output valid, output angle, input ready);
  modport sink   (input valid, input angle, output ready);
endinterface

interface sesp_sine_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sine_value;

  modport source (output valid, output sine_value, input ready);
  modport sink   (input valid, input sine_value, output ready);
endinterface

`default_nettype wire

/* rtl/core/sesp_poly.sv */
// Pipelined sine/cosine polynomial of the reduced angle (Q31 in and out).
// Depends on sesp_pkg; stage enables come from the top-level valid chain.
`default_nettype none

module sesp_poly (
  input  logic                                 clk_i,
  input  logic [sesp_pkg::POLY_STAGES-1:0]     adv_i,
  input  sesp_pkg::q31_t                       r_i,
  output sesp_pkg::q31_t                       sin_o,
  output sesp_pkg::q31_t                       cos_o
);
  import sesp_pkg::*;

  // stage 0
  prod_t rr_q;
  q31_t  r0_q;
  // stage 1
  q31_t  z1_q, r1_q;
  // stage 2
  prod_t zp2s_q, zp2c_q, zzp_q, rzp_q;
  q31_t  z2_q, r2_q;
  // stage 3
  q31_t  b3_q, d3_q, zz3_q, rz3_q, zh3_q, z3_q, r3_q;
  // stage 4
  prod_t zb4_q, zd4_q;
  q31_t  zz4_q, rz4_q, zh4_q, r4_q;
  // stage 5
  q31_t  ps5_q, pc5_q, zz5_q, rz5_q, zh5_q, r5_q;
  // stage 6
  prod_t sp6_q, cp6_q;
  q31_t  zh6_q, r6_q;
  // stage 7
  q31_t  s7_q, c7_q;

  always_ff @(posedge clk_i) begin
    if (adv_i[0]) begin
      rr_q <= prod_t'(r_i) * prod_t'(r_i);
      r0_q <= r_i;
    end
    if (adv_i[1]) begin
      z1_q <= rnd31(rr_q);
      r1_q <= r0_q;
    end
    if (adv_i[2]) begin
      zp2s_q <= prod_t'(z1_q) * prod_t'(P2S);
      zp2c_q <= prod_t'(z1_q) * prod_t'(P2C);
      zzp_q  <= prod_t'(z1_q) * prod_t'(z1_q);
      rzp_q  <= prod_t'(r1_q) * prod_t'(z1_q);
      z2_q   <= z1_q;
      r2_q   <= r1_q;
    end
    if (adv_i[3]) begin
      b3_q  <= P1S + rnd31(zp2s_q);
      d3_q  <= P1C + rnd31(zp2c_q);
      zz3_q <= rnd31(zzp_q);
      rz3_q <= rnd31(rzp_q);
      // z * 0.5 rounded half up
      zh3_q <= (z2_q + q31_t'(1)) >>> 1;
      z3_q  <= z2_q;
      r3_q  <= r2_q;
    end
    if (adv_i[4]) begin
      zb4_q <= prod_t'(z3_q) * prod_t'(b3_q);
      zd4_q <= prod_t'(z3_q) * prod_t'(d3_q);
      zz4_q <= zz3_q;
      rz4_q <= rz3_q;
      zh4_q <= zh3_q;
      r4_q  <= r3_q;
    end
    if (adv_i[5]) begin
      ps5_q <= P0S + rnd31(zb4_q);
      pc5_q <= P0C + rnd31(zd4_q);
      zz5_q <= zz4_q;
      rz5_q <= rz4_q;
      zh5_q <= zh4_q;
      r5_q  <= r4_q;
    end
    if (adv_i[6]) begin
      sp6_q <= prod_t'(rz5_q) * prod_t'(ps5_q);
      cp6_q <= prod_t'(zz5_q) * prod_t'(pc5_q);
      zh6_q <= zh5_q;
      r6_q  <= r5_q;
    end
    if (adv_i[7]) begin
      s7_q <= r6_q + rnd31(sp6_q);
      c7_q <= ONE_Q31 - zh6_q + rnd31(cp6_q);
    end
  end

  assign sin_o = s7_q;
  assign cos_o = c7_q;

endmodule

`default_nettype wire

/* rtl/core/sine_eight_sector_polynomial.sv */
// Sine unit top level: sector reduction, polynomial core and table rotation.
// Depends on sesp_pkg, sesp_if (sesp_angle_if, sesp_sine_if) and sesp_poly.
//
// Takes a Q8.24 angle in radians and returns its sine as Q1.30, saturated to
// [-1.0, +1.0]. The unit is a 14-stage pipeline: one angle is taken every
// clock cycle unless back-pressure holds the input; its stages carry the
// chain of multipliers (sector estimate, reduction, four polynomial multiply
// levels and the rotation), each followed by its own register. Every stage
// carries a valid bit and holds only while it and all stages ahead are full
// and sine_o is not ready, so bubbles fill before the input stalls.
`default_nettype none

module sine_eight_sector_polynomial #(
  parameter int SECTORS = sesp_pkg::SESP_SECTORS
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  sesp_angle_if.sink angle_i,
  sesp_sine_if.source sine_o
);
  import sesp_pkg::*;

  localparam int LOG_S      = $clog2(SECTORS);
  localparam int GRID_SHIFT = 4 - LOG_S;
  localparam int QW         = LOG_S + 7;
  localparam int QSW        = QW + STEP_W;
  localparam int AW         = PW + 1;
  localparam int NST        = SESP_STAGES;

  localparam logic [63:0]               STEP_Q48 = (((PI_Q60 >> 10) / SECTORS) + 1) >> 1;
  localparam logic signed [STEP_W-1:0]  STEP_S   = STEP_W'(STEP_Q48);

  localparam logic signed [63:0]  HALF_Q36 = 64'sd1 <<< 35;
  localparam logic signed [63:0]  HALF_Q17 = 64'sd65536;
  localparam logic signed [AW-1:0] RND32   = AW'(64'sh0000_0000_8000_0000);
  localparam logic signed [34:0]  OUT_MAX  = 35'sd1073741824;

  // Valid chain and stage enables
  logic [NST-1:0] v_q, en, v_in;

  always_comb begin
    for (int i = 0; i < NST; i++) begin
      // a stage may load when the output is ready or a stage from here on is empty
      en[i] = sine_o.ready ||
              ((v_q | ((NST'(1) << i) - NST'(1))) != {NST{1'b1}});
    end
  end

  assign v_in = {v_q[NST-2:0], angle_i.valid};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      for (int i = 0; i < NST; i++) begin
        if (en[i]) begin
          v_q[i] <= v_in[i];
        end
      end
    end
  end

  assign angle_i.ready = en[0];
  assign sine_o.valid  = v_q[NST-1];

  // Sector estimate and reduction
  logic signed [63:0]        p0_q;
  logic signed [31:0]        a0_q, a1_q, a2_q;
  logic signed [QW-1:0]      q1_q;
  logic signed [QSW-1:0]     qs2_q;
  q31_t                      r3_q;
  logic signed [63:0]        t_sh, r48;
  logic [LOG_S-1:0]          k_q [2:10];

  assign t_sh = ((p0_q >>> 21) <<< LOG_S) + HALF_Q36;
  assign r48  = (64'(a2_q) <<< 24) - 64'(qs2_q);

  always_ff @(posedge clk_i) begin
    if (en[0]) begin
      p0_q <= 64'(angle_i.angle) * 64'(INV_TWO_PI_Q33);
      a0_q <= angle_i.angle;
    end
    if (en[1]) begin
      q1_q <= QW'(t_sh >>> 36);
      a1_q <= a0_q;
    end
    if (en[2]) begin
      qs2_q   <= QSW'(q1_q) * QSW'(STEP_S);
      a2_q    <= a1_q;
      // q mod SECTORS: low bits of the two's complement sector number
      k_q[2]  <= q1_q[LOG_S-1:0];
    end
    if (en[3]) begin
      r3_q <= q31_t'((r48 + HALF_Q17) >>> 17);
    end
    for (int i = 3; i <= 10; i++) begin
      if (en[i]) begin
        k_q[i] <= k_q[i-1];
      end
    end
  end

  // Polynomial core, stages 4 to 11
  q31_t s_poly, c_poly;

  sesp_poly u_poly (
    .clk_i (clk_i),
    .adv_i (en[POLY_FIRST+POLY_STAGES-1:POLY_FIRST]),
    .r_i   (r3_q),
    .sin_o (s_poly),
    .cos_o (c_poly)
  );

  // Rotation table, looked up alongside the last polynomial stage
  logic [3:0] idx_c, idx_s;
  q31_t       rc_q, rs_q;

  assign idx_c = 4'(k_q[10]) << GRID_SHIFT;
  assign idx_s = idx_c + 4'd12;

  prod_t                 m1_q, m2_q;
  logic signed [AW-1:0]  acc;
  logic signed [34:0]    y_full;
  logic signed [31:0]    y_d, y_q;

  assign acc    = AW'(m1_q) + AW'(m2_q) + RND32;
  assign y_full = 35'(acc >>> 32);

  always_comb begin
    if (y_full > OUT_MAX) begin
      y_d = 32'(OUT_MAX);
    end else if (y_full < -OUT_MAX) begin
      y_d = 32'(-OUT_MAX);
    end else begin
      y_d = 32'(y_full);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en[11]) begin
      rc_q <= cos_grid(idx_c);
      rs_q <= cos_grid(idx_s);
    end
    if (en[12]) begin
      m1_q <= prod_t'(rs_q) * prod_t'(c_poly);
      m2_q <= prod_t'(rc_q) * prod_t'(s_poly);
    end
    if (en[13]) begin
      y_q <= y_d;
    end
  end

  assign sine_o.sine_value = y_q;

`ifndef ASSERT_OFF
  a_out_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    sine_o.valid |-> (sine_o.sine_value <= 32'sd1073741824 &&
                      sine_o.sine_value >= -32'sd1073741824))
    else $error("sine result outside saturation bounds");

  a_stall_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !angle_i.ready |-> (&v_q))
    else $error("input stalled while a pipeline stage is empty");

  a_accept_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (angle_i.valid && angle_i.ready) |=> v_q[0])
    else $error("accepted transaction lost at first stage");
`endif

endmodule

`default_nettype wire
